[sv/sws_pkg.sv]
// ----------------------------------------------------------------------------
// sws_pkg
// shared constants, codes and types of the sliding window sender
// ----------------------------------------------------------------------------
package sws_pkg;

    // window slot table
    localparam int SLOTS      = 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SEQ_W      = 16;
    localparam int FRAME_W    = 16;
    localparam int WIN_W      = 7;
    localparam int SLOT_OUT_W = 6;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_MAXSEQ = 1'b1;

    localparam logic [WIN_W-1:0] WIN_RESET    = 7'd8;
    localparam logic [SEQ_W-1:0] MAXSEQ_RESET = 16'hFFFF;

    // operation codes of an input beat
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    // token that walks the cell chain looking for a slot
    typedef struct packed {
        logic              valid;
        logic              free_found;
        logic              any;
        logic [SLOT_W-1:0] idx;
        logic [SEQ_W-1:0]  seq;
    } t_carry;

    // broadcast write of a granted frame
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  idx;
        logic [SEQ_W-1:0]   seq;
        logic [FRAME_W-1:0] frame;
    } t_slot_wr;

    // broadcast ack mark
    typedef struct packed {
        logic             en;
        logic [SEQ_W-1:0] target;
    } t_mark;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ADVANCE,
        ST_FINISH
    } t_state;

endpackage

[sv/sliding_window_sender_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_sender_unit
// sender side of a sliding window protocol with a row of window slot cells
// ----------------------------------------------------------------------------
// Each input beat is either a send request or an acknowledgement, and each
// gives exactly one result beat. The block works on one beat at a time; the
// input is stalled while it is busy, but a result waiting at the output does
// not stop the next beat from being taken. A send that is refused (window
// full or max_sequence reached) goes straight to the finish state. A granted
// send runs a search: a search token walks the row of slot cells one cell per
// cycle to find the first free slot or else the oldest one. For an ack, the
// ack mark is applied to all cells at once, then last_acked moves over
// contiguous acked slots, one slot per cycle, at most SLOTS steps.
// Configuration lives at byte address 0 (window_size) and 4 (max_sequence)
// and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_sender_unit
    import sws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [FRAME_W-1:0]    i_frame_number,
    input  logic [SEQ_W-1:0]      i_ack_next,

    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_granted,
    output logic [SEQ_W-1:0]      o_sent_sequence,
    output logic [SLOT_OUT_W-1:0] o_slot_used,
    output logic [SEQ_W-1:0]      o_last_acked,

    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(SLOTS - 1);

    // configuration registers
    logic [WIN_W-1:0] r_win;
    logic [SEQ_W-1:0] r_max;

    // protocol state
    t_state              r_state, n_state;
    logic [SEQ_W-1:0]    r_lar, n_lar;        // last acknowledged
    logic [SEQ_W-1:0]    r_lfs, n_lfs;        // last sent
    logic                r_launch, n_launch;  // token into cell 0
    logic [SLOT_W-1:0]   r_step, n_step;      // ack advance steps taken
    logic [FRAME_W-1:0]  r_frame, n_frame;

    // pending result
    logic                  r_res_granted, n_res_granted;
    logic [SEQ_W-1:0]      r_res_seq, n_res_seq;
    logic [SLOT_OUT_W-1:0] r_res_slot, n_res_slot;

    // output register
    logic                  r_out_valid;
    logic                  r_out_granted;
    logic [SEQ_W-1:0]      r_out_seq;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic [SEQ_W-1:0]      r_out_last;

    // cell row
    t_carry           w_carry [SLOTS+1];
    logic [SLOTS-1:0] w_hit;
    logic [SLOTS-1:0] w_active;
    logic [SLOTS:0]   w_chain_valid;
    t_slot_wr         w_wr;
    t_mark            w_mark;
    logic [SEQ_W-1:0] w_want;

    logic             w_cfg_wr;
    logic             w_out_free;
    logic             w_load_out;
    logic [WIN_W-1:0] w_act_cnt;
    logic [SEQ_W-1:0] w_outstanding;
    logic             w_grant_ok;

    // ------------------------------------------------------------------
    // configuration port, zero wait state
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
            r_max <= MAXSEQ_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_WINDOW: r_win <= pwdata[WIN_W-1:0];
                REG_MAXSEQ: r_max <= pwdata[SEQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WINDOW: prdata = {{(APB_DATA_W-WIN_W){1'b0}}, r_win};
            REG_MAXSEQ: prdata = {{(APB_DATA_W-SEQ_W){1'b0}}, r_max};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // window bookkeeping
    // ------------------------------------------------------------------
    // slots at or beyond window_size sit out of placement and acks
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_active[i] = (r_win > WIN_W'(i));
        end
    end

    assign w_act_cnt     = (r_win > WIN_W'(SLOTS)) ? WIN_W'(SLOTS) : r_win;
    assign w_outstanding = (r_lfs >= r_lar) ? (r_lfs - r_lar) : '0;
    assign w_grant_ok    = (r_lfs < r_max)
                           && (w_outstanding < {{(SEQ_W-WIN_W){1'b0}}, w_act_cnt});

    assign w_want     = r_lar + SEQ_W'(1);
    assign w_out_free = !r_out_valid || !i_stall;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_lar         = r_lar;
        n_lfs         = r_lfs;
        n_launch      = 1'b0;
        n_step        = r_step;
        n_frame       = r_frame;
        n_res_granted = r_res_granted;
        n_res_seq     = r_res_seq;
        n_res_slot    = r_res_slot;
        w_wr          = '0;
        w_mark        = '0;
        w_load_out    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_res_granted = 1'b0;
                    n_res_seq     = '0;
                    n_res_slot    = '0;
                    if (i_operation == OP_ACK) begin
                        // mark every matching cell at the accept edge
                        w_mark.en     = 1'b1;
                        w_mark.target = i_ack_next - SEQ_W'(1);
                        n_step        = '0;
                        n_state       = ST_ADVANCE;
                    end else if (w_grant_ok) begin
                        n_lfs         = r_lfs + SEQ_W'(1);
                        n_res_granted = 1'b1;
                        n_res_seq     = r_lfs + SEQ_W'(1);
                        n_frame       = i_frame_number;
                        n_launch      = 1'b1;
                        n_state       = ST_SEARCH;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end

            ST_SEARCH: begin
                // token has left the last cell: write the chosen slot
                if (w_carry[SLOTS].valid) begin
                    w_wr.en    = 1'b1;
                    w_wr.idx   = w_carry[SLOTS].idx;
                    w_wr.seq   = r_res_seq;
                    w_wr.frame = r_frame;
                    n_res_slot = SLOT_OUT_W'(w_carry[SLOTS].idx);
                    n_state    = ST_FINISH;
                end
            end

            ST_ADVANCE: begin
                if (|w_hit) begin
                    n_lar = w_want;
                    if (r_step == LAST_STEP) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_step = r_step + SLOT_W'(1);
                    end
                end else begin
                    n_state = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_lar    <= '0;
            r_lfs    <= '0;
            r_launch <= 1'b0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_lar    <= n_lar;
            r_lfs    <= n_lfs;
            r_launch <= n_launch;
            r_step   <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame       <= n_frame;
        r_res_granted <= n_res_granted;
        r_res_seq     <= n_res_seq;
        r_res_slot    <= n_res_slot;
    end

    // ------------------------------------------------------------------
    // output register, loads when empty or while the previous beat is taken
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_granted <= r_res_granted;
            r_out_seq     <= r_res_seq;
            r_out_slot    <= r_res_slot;
            r_out_last    <= r_lar;
        end
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_granted       = r_out_granted;
    assign o_sent_sequence = r_out_seq;
    assign o_slot_used     = r_out_slot;
    assign o_last_acked    = r_out_last;

    // ------------------------------------------------------------------
    // row of slot cells
    // ------------------------------------------------------------------
    always_comb begin
        w_carry[0]            = '0;
        w_carry[0].valid      = r_launch;
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            sws_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_idx    (SLOT_W'(g)),
                .i_active (w_active[g]),
                .i_carry  (w_carry[g]),
                .o_carry  (w_carry[g+1]),
                .i_wr     (w_wr),
                .i_mark   (w_mark),
                .i_want   (w_want),
                .o_hit    (w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        for (int i = 0; i <= SLOTS; i++) begin
            w_chain_valid[i] = w_carry[i].valid;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a single search token in flight at most
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_chain_valid))
        else $error("more than one search token in the cell row");

    // the token only exists while a search runs
    a_token_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_chain_valid) |-> (r_state == ST_SEARCH))
        else $error("search token outside a search");

    // acks never run past what was sent
    a_lar_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lar <= r_lfs)
        else $error("last acked beyond last sent");

    // a grant always carries a nonzero sequence
    a_grant_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted) |-> (o_sent_sequence != '0))
        else $error("granted beat with zero sequence");

    // a granted send bumps last sent by exactly one
    a_send_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid && i_operation == OP_SEND && w_grant_ok)
        |=> (r_lfs == $past(r_lfs) + SEQ_W'(1)))
        else $error("last sent did not step by one on a grant");

endmodule

[sv/sws_cell.sv]
// ----------------------------------------------------------------------------
// sws_cell
// one window slot: holds sequence, frame and marks, takes part in the
// slot search token and answers ack compares
// ----------------------------------------------------------------------------
module sws_cell
    import sws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  logic              i_active,
    input  t_carry            i_carry,
    output t_carry            o_carry,
    input  t_slot_wr          i_wr,
    input  t_mark             i_mark,
    input  logic [SEQ_W-1:0]  i_want,
    output logic              o_hit
);

    logic [SEQ_W-1:0]   r_seq;
    logic [FRAME_W-1:0] r_frame;
    logic               r_acked;
    logic               r_occupied;
    t_carry             r_carry;
    t_carry             n_carry;

    // first free slot wins, else smallest sequence, lowest index on a tie
    always_comb begin
        n_carry = i_carry;
        if (i_carry.valid && i_active && !i_carry.free_found) begin
            if (!r_occupied) begin
                n_carry.free_found = 1'b1;
                n_carry.idx        = i_idx;
            end else if (!i_carry.any || (r_seq < i_carry.seq)) begin
                n_carry.any = 1'b1;
                n_carry.idx = i_idx;
                n_carry.seq = r_seq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.valid <= 1'b0;
        end else begin
            r_carry.valid <= n_carry.valid;
        end
        r_carry.free_found <= n_carry.free_found;
        r_carry.any        <= n_carry.any;
        r_carry.idx        <= n_carry.idx;
        r_carry.seq        <= n_carry.seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= '0;
            r_acked    <= 1'b0;
            r_occupied <= 1'b0;
        end else if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_seq      <= i_wr.seq;
            r_acked    <= 1'b0;
            r_occupied <= 1'b1;
        end else if (i_mark.en && i_active && r_occupied && (r_seq == i_mark.target)) begin
            r_acked <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_frame <= i_wr.frame;
        end
    end

    assign o_carry = r_carry;
    assign o_hit   = i_active && r_occupied && r_acked && (r_seq == i_want)
                     && (r_frame == r_frame);

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sliding window sender unit
// ----------------------------------------------------------------------------
// A local window predictor tracks the sequence counter, the last acked number
// and the slot table. Each beat accepted on the input is run through it and
// the outcome is queued. The result checker compares every result beat field
// by field with the oldest queued outcome. Test tasks cover directed window
// cases, register extremes, random phases with changing settings, a stretch
// without idling, a long output hold-off and a full sender pause.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sws_pkg::*;

    localparam int IDLE_PCT        = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 2 * SLOTS + 4;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 7;
    localparam int PHASE_BEATS     = 115;

    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_MAXSEQ = {REG_MAXSEQ, 2'b00};

    typedef struct packed {
        logic                  granted;
        logic [SEQ_W-1:0]      seq;
        logic [SLOT_OUT_W-1:0] slot;
        logic [SEQ_W-1:0]      acked;
    } t_outcome;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel
    logic               in_valid     = 1'b0;
    logic               in_operation = OP_SEND;
    logic [FRAME_W-1:0] in_frame     = '0;
    logic [SEQ_W-1:0]   in_ack_next  = '0;
    logic               o_stall;

    // output channel
    logic                  o_valid;
    logic                  out_stall = 1'b0;
    logic                  o_granted;
    logic [SEQ_W-1:0]      o_sent_sequence;
    logic [SLOT_OUT_W-1:0] o_slot_used;
    logic [SEQ_W-1:0]      o_last_acked;

    // configuration port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // idling control shared with the stall process
    logic quiet     = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_cnt  = 0;

    int idle_cycles = 0;
    int mismatches  = 0;

    // predictor state
    logic [WIN_W-1:0] tx_window   = WIN_RESET;
    logic [SEQ_W-1:0] tx_max_seq  = MAXSEQ_RESET;
    logic [SEQ_W-1:0] tx_last_ack = '0;
    logic [SEQ_W-1:0] tx_last_sent = '0;
    logic [SEQ_W-1:0] tx_slot_seq [SLOTS] = '{default: '0};
    bit               tx_slot_used [SLOTS] = '{default: 1'b0};
    bit               tx_slot_acked [SLOTS] = '{default: 1'b0};

    t_outcome expected_outcomes [$];

    sliding_window_sender_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (o_stall),
        .i_operation     (in_operation),
        .i_frame_number  (in_frame),
        .i_ack_next      (in_ack_next),
        .o_valid         (o_valid),
        .i_stall         (out_stall),
        .o_granted       (o_granted),
        .o_sent_sequence (o_sent_sequence),
        .o_slot_used     (o_slot_used),
        .o_last_acked    (o_last_acked),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // window predictor
    // ------------------------------------------------------------------

    // slots taking part: window size capped at the slot count
    function automatic int active_count();
        return (int'(tx_window) < SLOTS) ? int'(tx_window) : SLOTS;
    endfunction

    function automatic t_outcome window_step(input logic op, input logic [SEQ_W-1:0] nxt);
        t_outcome         res;
        int               n;
        int               pick;
        int               backlog;
        bit               have;
        bit               hit;
        logic [SEQ_W-1:0] target;
        logic [SEQ_W-1:0] want;
        res = '0;
        n = active_count();
        if (op == OP_SEND) begin
            backlog = (tx_last_sent >= tx_last_ack) ?
                      int'(tx_last_sent) - int'(tx_last_ack) : 0;
            if (tx_last_sent < tx_max_seq && backlog < n) begin
                tx_last_sent = tx_last_sent + 16'd1;
                have = 1'b0;
                pick = 0;
                // first free slot, else oldest sequence, lowest index on a tie
                for (int i = 0; i < n; i++) begin
                    if (!have && !tx_slot_used[i]) begin
                        pick = i;
                        have = 1'b1;
                    end
                end
                if (!have) begin
                    for (int i = 1; i < n; i++) begin
                        if (tx_slot_seq[i] < tx_slot_seq[pick]) pick = i;
                    end
                end
                tx_slot_seq[pick]   = tx_last_sent;
                tx_slot_acked[pick] = 1'b0;
                tx_slot_used[pick]  = 1'b1;
                res.granted = 1'b1;
                res.seq     = tx_last_sent;
                res.slot    = SLOT_OUT_W'(pick);
            end
        end else begin
            target = nxt - 16'd1;
            for (int i = 0; i < n; i++) begin
                if (tx_slot_used[i] && tx_slot_seq[i] == target) tx_slot_acked[i] = 1'b1;
            end
            // walk over contiguous acked slots, bounded by the slot count
            for (int s = 0; s < SLOTS; s++) begin
                want = tx_last_ack + 16'd1;
                hit  = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (tx_slot_used[i] && tx_slot_acked[i] && tx_slot_seq[i] == want) hit = 1'b1;
                end
                if (!hit) break;
                tx_last_ack = want;
            end
        end
        res.acked = tx_last_ack;
        return res;
    endfunction

    // ack value of a well-formed acknowledgement: in order or any open frame
    function automatic logic [SEQ_W-1:0] next_ack_value();
        logic [SEQ_W-1:0] open_seqs [$];
        logic [SEQ_W-1:0] in_order;
        int               n;
        in_order = tx_last_ack + 16'd1;
        n = active_count();
        for (int i = 0; i < n; i++) begin
            if (tx_slot_used[i] && !tx_slot_acked[i] && tx_slot_seq[i] > tx_last_ack)
                open_seqs.push_back(tx_slot_seq[i]);
        end
        if (open_seqs.size() == 0) return in_order + 16'($urandom_range(0, 3));
        foreach (open_seqs[k]) begin
            if (open_seqs[k] == in_order && $urandom_range(1) == 1) return in_order + 16'd1;
        end
        return open_seqs[$urandom_range(open_seqs.size() - 1)] + 16'd1;
    endfunction

    // ------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic op, input logic [FRAME_W-1:0] frame,
                             input logic [SEQ_W-1:0] nxt);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_operation <= op;
        in_frame     <= frame;
        in_ack_next  <= nxt;
        do @(posedge clk); while (o_stall);
        expected_outcomes.push_back(window_step(op, nxt));
    endtask

    task automatic random_beat();
        int r;
        r = $urandom_range(99);
        if (r < 48) begin
            send_beat(OP_SEND, 16'($urandom()), 16'($urandom()));
        end else if (r < 90) begin
            send_beat(OP_ACK, 16'($urandom()), next_ack_value());
        end else begin
            send_beat(OP_ACK, 16'($urandom()), 16'($urandom()));
        end
    endtask

    // stop sending until every result is in, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write a register while idle, then read it back
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] mask;
        logic [APB_DATA_W-1:0] got;
        wait_idle();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_WINDOW) begin
            tx_window = data[WIN_W-1:0];
            mask = {{(APB_DATA_W-WIN_W){1'b0}}, {WIN_W{1'b1}}};
        end else begin
            tx_max_seq = data[SEQ_W-1:0];
            mask = {{(APB_DATA_W-SEQ_W){1'b0}}, {SEQ_W{1'b1}}};
        end
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) != (data & mask))
            report_mismatch($sformatf("register %0h read %0h want %0h",
                                      addr, got & mask, data & mask));
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // reset settings: wrap ack, full window, out of order acks, replacement
    task automatic test_directed_window();
        send_beat(OP_ACK, 16'h0000, 16'h0000);
        send_beat(OP_ACK, 16'hFFFF, 16'hFFFF);
        send_beat(OP_SEND, 16'h0000, 16'h0000);
        send_beat(OP_SEND, 16'hFFFF, 16'hFFFF);
        repeat (6) send_beat(OP_SEND, 16'($urandom()), 16'($urandom()));
        send_beat(OP_SEND, 16'h1234, 16'h0000);
        send_beat(OP_ACK, 16'h0000, 16'd3);
        send_beat(OP_ACK, 16'h0000, 16'd2);
        send_beat(OP_ACK, 16'h0000, 16'd2);
        send_beat(OP_ACK, 16'h0000, 16'd5);
        send_beat(OP_ACK, 16'h0000, 16'd4);
        send_beat(OP_SEND, 16'hA5A5, 16'h0000);
        send_beat(OP_ACK, 16'h0000, 16'd10);
        send_beat(OP_ACK, 16'h0000, 16'd100);
    endtask

    // zero window, single slot, oversize window, sequence limit
    task automatic test_register_extremes();
        logic [SEQ_W-1:0] limit;
        write_register(ADDR_WINDOW, 32'h0000_0000);
        send_beat(OP_SEND, 16'($urandom()), 16'($urandom()));
        send_beat(OP_ACK, 16'($urandom()), next_ack_value());
        write_register(ADDR_WINDOW, 32'hFFFF_FF81);
        send_beat(OP_SEND, 16'($urandom()), 16'($urandom()));
        send_beat(OP_ACK, 16'($urandom()), next_ack_value());
        send_beat(OP_SEND, 16'($urandom()), 16'($urandom()));
        write_register(ADDR_WINDOW, 32'h0000_007F);
        repeat (3) send_beat(OP_SEND, 16'($urandom()), 16'($urandom()));
        repeat (3) send_beat(OP_ACK, 16'($urandom()), next_ack_value());
        write_register(ADDR_WINDOW, 32'h0000_0040);
        write_register(ADDR_MAXSEQ, 32'hFFFF_0000);
        send_beat(OP_SEND, 16'($urandom()), 16'($urandom()));
        write_register(ADDR_MAXSEQ, 32'h0000_0001);
        send_beat(OP_SEND, 16'($urandom()), 16'($urandom()));
        // limit just ahead of the counter: two grants, then refusals
        limit = tx_last_sent + 16'd2;
        write_register(ADDR_MAXSEQ, {16'h5A5A, limit});
        repeat (2) begin
            send_beat(OP_SEND, 16'($urandom()), 16'($urandom()));
            send_beat(OP_ACK, 16'($urandom()), next_ack_value());
            send_beat(OP_SEND, 16'($urandom()), 16'($urandom()));
        end
        write_register(ADDR_MAXSEQ, 32'h0000_FFFF);
        write_register(ADDR_WINDOW, 32'h0000_0008);
    endtask

    // random settings per phase, mostly well-formed traffic
    task automatic test_random_phases();
        int                    r;
        int                    lim;
        logic [WIN_W-1:0]      win;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            r = $urandom_range(99);
            if (r < 8) win = '0;
            else if (r < 25) win = WIN_W'($urandom_range(9, 127));
            else win = WIN_W'($urandom_range(1, SLOTS));
            write_register(ADDR_WINDOW, ($urandom() & ~32'h7F) | APB_DATA_W'(win));
            if ($urandom_range(3) == 0) begin
                lim = int'(tx_last_sent) + $urandom_range(0, 12);
                if (lim > 65535) lim = 65535;
            end else begin
                lim = 65535;
            end
            write_register(ADDR_MAXSEQ, ($urandom() & ~32'hFFFF) | APB_DATA_W'(lim));
            repeat (PHASE_BEATS) random_beat();
        end
        write_register(ADDR_WINDOW, 32'h0000_0008);
        write_register(ADDR_MAXSEQ, 32'h0000_FFFF);
    endtask

    // back-to-back beats on both sides
    task automatic test_no_idle_stretch();
        quiet <= 1'b1;
        repeat (100) random_beat();
        quiet <= 1'b0;
    endtask

    // output held off long enough for the input to stall
    task automatic test_output_hold_off();
        hold_req <= ~hold_req;
        repeat (40) random_beat();
    endtask

    // sender stops until every result has come back
    task automatic test_sender_pause();
        repeat (20) random_beat();
        wait_idle();
        repeat (20) random_beat();
    endtask

    // ------------------------------------------------------------------
    // processes
    // ------------------------------------------------------------------

    // output stall: random idling, or a counted hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
            hold_seen <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt  <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // result beat check against the oldest expected outcome
    always @(posedge clk) begin : result_check
        t_outcome want;
        if (rst_n && o_valid && !out_stall) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = expected_outcomes.pop_front();
                if (o_granted !== want.granted)
                    report_mismatch($sformatf("granted %0h want %0h", o_granted, want.granted));
                if (o_sent_sequence !== want.seq)
                    report_mismatch($sformatf("sent_sequence %0h want %0h",
                                              o_sent_sequence, want.seq));
                if (o_slot_used !== want.slot)
                    report_mismatch($sformatf("slot_used %0h want %0h", o_slot_used, want.slot));
                if (o_last_acked !== want.acked)
                    report_mismatch($sformatf("last_acked %0h want %0h",
                                              o_last_acked, want.acked));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_stall) || (o_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_window();
        test_register_extremes();
        test_random_phases();
        test_no_idle_stretch();
        test_output_hold_off();
        test_sender_pause();
        wait_idle();
        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
